>>> rtl/tsa_pkg.sv
// tsa_pkg: shared types and constants for the typematic step accelerator
// used by tsa_cfg_regs, tsa_ctrl, tsa_datapath and the top level
package tsa_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_MIN_TAPS       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPRESS_WINDOW = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_WINDOW    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_PERIOD    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_MAX       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_REPRESS_PERIOD = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_REPRESS_MAX    = 3'd6;

  localparam logic [7:0]  RST_MIN_TAPS       = 8'd2;
  localparam logic [15:0] RST_REPRESS_WINDOW = 16'd500;
  localparam logic [15:0] RST_HOLD_WINDOW    = 16'd100;
  localparam logic [15:0] RST_HOLD_PERIOD    = 16'd1000;
  localparam logic [7:0]  RST_HOLD_MAX       = 8'd20;
  localparam logic [15:0] RST_REPRESS_PERIOD = 16'd1000;
  localparam logic [7:0]  RST_REPRESS_MAX    = 8'd10;

  localparam logic [7:0] TAP_SAT = 8'd255;

  typedef struct packed {
    logic [7:0]  min_taps;
    logic [15:0] repress_window;
    logic [15:0] hold_window;
    logic [15:0] hold_period;
    logic [7:0]  hold_max;
    logic [15:0] repress_period;
    logic [7:0]  repress_max;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_REPRESS,
    MODE_RESTART
  } mode_e;

  typedef struct packed {
    logic load;
    logic iter;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

>>> rtl/tsa_cfg_regs.sv
// tsa_cfg_regs: configuration register file of the step accelerator
// depends on tsa_pkg for register indexes, reset values and cfg_t
module tsa_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [tsa_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [15:0]                  wr_data_i,
  output tsa_pkg::cfg_t                cfg_o
);

  tsa_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        tsa_pkg::CFG_MIN_TAPS:       cfg_d.min_taps       = wr_data_i[7:0];
        tsa_pkg::CFG_REPRESS_WINDOW: cfg_d.repress_window = wr_data_i;
        tsa_pkg::CFG_HOLD_WINDOW:    cfg_d.hold_window    = wr_data_i;
        tsa_pkg::CFG_HOLD_PERIOD:    cfg_d.hold_period    = wr_data_i;
        tsa_pkg::CFG_HOLD_MAX:       cfg_d.hold_max       = wr_data_i[7:0];
        tsa_pkg::CFG_REPRESS_PERIOD: cfg_d.repress_period = wr_data_i;
        tsa_pkg::CFG_REPRESS_MAX:    cfg_d.repress_max    = wr_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_taps       <= tsa_pkg::RST_MIN_TAPS;
      cfg_q.repress_window <= tsa_pkg::RST_REPRESS_WINDOW;
      cfg_q.hold_window    <= tsa_pkg::RST_HOLD_WINDOW;
      cfg_q.hold_period    <= tsa_pkg::RST_HOLD_PERIOD;
      cfg_q.hold_max       <= tsa_pkg::RST_HOLD_MAX;
      cfg_q.repress_period <= tsa_pkg::RST_REPRESS_PERIOD;
      cfg_q.repress_max    <= tsa_pkg::RST_REPRESS_MAX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/tsa_ctrl.sv
// tsa_ctrl: sequencer of the step accelerator, counts divider iterations
// depends on tsa_pkg for state_e, cmd_t and status_t
module tsa_ctrl #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  input  tsa_pkg::status_t  status_i,
  output tsa_pkg::cmd_t     cmd_o
);

  localparam int unsigned CntW = $clog2(TIME_BITS);

  tsa_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tsa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CntW'(TIME_BITS - 1);
          state_d    = tsa_pkg::ST_DIV;
        end
      end
      tsa_pkg::ST_DIV: begin
        cmd_o.iter = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = tsa_pkg::ST_DONE;
        end
      end
      tsa_pkg::ST_DONE: begin
        if (!status_i.out_valid || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = tsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsa_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_load_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == tsa_pkg::ST_DIV && cnt_q == CntW'(TIME_BITS - 1))
    else $error("load did not start the divider");

  a_div_runs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tsa_pkg::ST_DIV && cnt_q != '0 |=> state_q == tsa_pkg::ST_DIV)
    else $error("divider left before its last iteration");

  a_finish_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !status_i.out_valid || out_ready_i)
    else $error("finish would overwrite a pending result");

endmodule

>>> rtl/tsa_datapath.sv
// tsa_datapath: press state, window classification, bit-serial divider and
// result register; depends on tsa_pkg for cfg_t, cmd_t, status_t and mode_e
module tsa_datapath #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned ID_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsa_pkg::cfg_t        cfg_i,
  input  tsa_pkg::cmd_t        cmd_i,
  output tsa_pkg::status_t     status_o,
  input  logic [TIME_BITS-1:0] now_ms_i,
  input  logic [ID_BITS-1:0]   target_id_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           step_count_o
);

  logic [TIME_BITS-1:0] prev_press_q, prev_press_d;
  logic [TIME_BITS-1:0] burst_q, burst_d;
  logic [7:0]           tap_q, tap_d;
  logic [ID_BITS-1:0]   prev_target_q, prev_target_d;

  tsa_pkg::mode_e       mode_q, mode_d;
  logic [15:0]          div_q, div_d;
  logic [7:0]           max_q, max_d;
  logic [TIME_BITS-1:0] dvd_q, dvd_d;
  logic [15:0]          rem_q, rem_d;

  logic                 out_valid_q, out_valid_d;
  logic [7:0]           step_q, step_d;

  logic                 same_target;
  logic [TIME_BITS-1:0] eff_prev, eff_burst, last_gap, first_gap;
  logic [7:0]           eff_tap;
  logic                 in_repress, in_hold, restart;
  logic [16:0]          rem_sh;
  logic                 q_bit;
  logic                 sat;

  // press classification on the accepted word
  always_comb begin
    same_target = (target_id_i == prev_target_q);
    eff_prev    = same_target ? prev_press_q : '0;
    eff_burst   = same_target ? burst_q : '0;
    eff_tap     = same_target ? tap_q : '0;
    last_gap    = now_ms_i - eff_prev;
    first_gap   = now_ms_i - eff_burst;
    in_repress  = last_gap < TIME_BITS'(cfg_i.repress_window);
    in_hold     = last_gap < TIME_BITS'(cfg_i.hold_window);
    restart     = !in_hold && !in_repress;
  end

  // one restoring division step
  always_comb begin
    rem_sh = {rem_q, dvd_q[TIME_BITS-1]};
    q_bit  = rem_sh >= {1'b0, div_q};
  end

  assign sat = dvd_q >= TIME_BITS'(max_q);

  always_comb begin
    prev_press_d  = prev_press_q;
    burst_d       = burst_q;
    tap_d         = tap_q;
    prev_target_d = prev_target_q;
    mode_d        = mode_q;
    div_d         = div_q;
    max_d         = max_q;
    dvd_d         = dvd_q;
    rem_d         = rem_q;
    out_valid_d   = out_valid_q;
    step_d        = step_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      prev_press_d  = now_ms_i;
      prev_target_d = target_id_i;
      if (restart || (in_repress && eff_tap < cfg_i.min_taps)) begin
        burst_d = now_ms_i;
      end else begin
        burst_d = eff_burst;
      end
      if (restart) begin
        tap_d = 8'd1;
      end else if (eff_tap == tsa_pkg::TAP_SAT) begin
        tap_d = tsa_pkg::TAP_SAT;
      end else begin
        tap_d = eff_tap + 8'd1;
      end
      if (in_hold) begin
        mode_d = tsa_pkg::MODE_HOLD;
        div_d  = cfg_i.hold_period;
        max_d  = cfg_i.hold_max;
      end else if (in_repress) begin
        mode_d = tsa_pkg::MODE_REPRESS;
        div_d  = cfg_i.repress_period;
        max_d  = cfg_i.repress_max;
      end else begin
        mode_d = tsa_pkg::MODE_RESTART;
        div_d  = cfg_i.repress_period;
        max_d  = cfg_i.repress_max;
      end
      dvd_d = first_gap;
      rem_d = '0;
    end

    if (cmd_i.iter) begin
      rem_d = q_bit ? 16'(rem_sh - {1'b0, div_q}) : rem_sh[15:0];
      dvd_d = {dvd_q[TIME_BITS-2:0], q_bit};
    end

    // a zero period yields an all-ones quotient, so outside restart mode it saturates here
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      if (mode_q == tsa_pkg::MODE_RESTART) begin
        step_d = 8'd1;
      end else if (sat) begin
        step_d = max_q;
      end else begin
        step_d = dvd_q[7:0] + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_press_q  <= '0;
      burst_q       <= '0;
      tap_q         <= '0;
      prev_target_q <= '0;
      out_valid_q   <= 1'b0;
      mode_q        <= tsa_pkg::MODE_RESTART;
    end else begin
      prev_press_q  <= prev_press_d;
      burst_q       <= burst_d;
      tap_q         <= tap_d;
      prev_target_q <= prev_target_d;
      out_valid_q   <= out_valid_d;
      mode_q        <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    max_q  <= max_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    step_q <= step_d;
  end

  assign status_o.out_valid = out_valid_q;
  assign out_valid_o        = out_valid_q;
  assign step_count_o       = step_q;

  a_tap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> tap_q != 8'd0)
    else $error("tap count zero after a press");

  a_target_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> prev_target_q == $past(target_id_i) && prev_press_q == $past(now_ms_i))
    else $error("press state not stored");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(step_q))
    else $error("pending result dropped or changed");

endmodule

>>> rtl/typematic_step_accelerator_core.sv
// typematic_step_accelerator_core: top level of the key repeat step accelerator
// depends on tsa_pkg, tsa_cfg_regs, tsa_ctrl and tsa_datapath
//
// Each accepted word is one key or button press (timestamp and target id) and
// yields one step size. The press is classified in the cycle it is accepted,
// then it passes the bit-serial divider, which produces one quotient bit per
// cycle, and the step is saturated and registered when no earlier result is
// pending or that one is being taken. A new press is taken only once the last
// one is done. The input side is ready again as soon as the result is
// registered, even while that result still waits to be taken. Configuration
// writes are taken every cycle and must only be issued while no press is in
// flight.
module typematic_step_accelerator_core #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned ID_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [TIME_BITS-1:0]         now_ms_i,
  input  logic [ID_BITS-1:0]           target_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   step_count_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tsa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]                  cfg_data_i
);

  tsa_pkg::cfg_t    cfg;
  tsa_pkg::cmd_t    cmd;
  tsa_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  tsa_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  tsa_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tsa_datapath #(
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .now_ms_i     (now_ms_i),
    .target_id_i  (target_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .step_count_o (step_count_o)
  );

endmodule
